@@ src/bfa_pkg.sv @@
`default_nettype none

package bfa_pkg;

  // Map geometry.
  localparam int MAX_ENTRIES   = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_DEPTH     = (MAX_ENTRIES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int WORD_W        = $clog2(MAP_DEPTH);

  // Field widths fixed by the interface.
  localparam int NUM_W   = 16;
  localparam int COUNT_W = 13;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Register indexes on the configuration port (byte address bits 3:2).
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_FIRST = 2'd2;

  localparam logic [COUNT_W-1:0] REG_COUNT_RESET = COUNT_W'(MAX_ENTRIES);

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0]   region_base;
    logic [COUNT_W-1:0] region_count;
    logic               first_index;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    issue;
    logic    free_read;
    logic    alloc_write;
    logic    free_write;
    logic    respond;
    status_t resp_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_mode;
    logic empty_range;
    logic out_of_range;
    logic more_words;
    logic eval_live;
    logic found;
    logic eval_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/bfa_ram.sv @@
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/bfa_regs.sv @@
`default_nettype none

module bfa_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfa_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bfa_pkg::DATA_W-1:0]    pwdata,
  output logic      [bfa_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output bfa_pkg::cfg_t                      cfg
);
  import bfa_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_base  <= '0;
      cfg.region_count <= REG_COUNT_RESET;
      cfg.first_index  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE:  cfg.region_base  <= pwdata[NUM_W-1:0];
        REG_COUNT: cfg.region_count <= pwdata[COUNT_W-1:0];
        REG_FIRST: cfg.first_index  <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE:  prdata = DATA_W'(cfg.region_base);
      REG_COUNT: prdata = DATA_W'(cfg.region_count);
      REG_FIRST: prdata = DATA_W'(cfg.first_index);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/bfa_ctrl.sv @@
`default_nettype none

module bfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire bfa_pkg::dp_stat_t stat,
  output bfa_pkg::cmd_t          cmd
);
  import bfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FREE_WR
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.resp_code = ST_DONE;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.req_mode == MODE_ALLOC) begin
          if (stat.empty_range) begin
            cmd.respond   = 1'b1;
            cmd.resp_code = ST_FULL;
            state_next    = S_IDLE;
          end else begin
            cmd.issue  = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          if (stat.out_of_range) begin
            cmd.respond   = 1'b1;
            cmd.resp_code = ST_RANGE;
            state_next    = S_IDLE;
          end else begin
            cmd.free_read = 1'b1;
            state_next    = S_FREE_WR;
          end
        end
      end
      S_SCAN: begin
        // Reads run one word ahead of the search.
        cmd.issue = stat.more_words;
        if (stat.eval_live) begin
          if (stat.found) begin
            cmd.alloc_write = 1'b1;
            cmd.respond     = 1'b1;
            cmd.resp_code   = ST_DONE;
            state_next      = S_IDLE;
          end else if (stat.eval_last) begin
            cmd.respond   = 1'b1;
            cmd.resp_code = ST_FULL;
            state_next    = S_IDLE;
          end
        end
      end
      S_FREE_WR: begin
        cmd.free_write = 1'b1;
        cmd.respond    = 1'b1;
        cmd.resp_code  = ST_DONE;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

@@ src/bfa_dp.sv @@
`default_nettype none

module bfa_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bfa_pkg::cfg_t               cfg,
  input  wire logic                        mode,
  input  wire logic [bfa_pkg::NUM_W-1:0]   entry_number,
  input  wire bfa_pkg::cmd_t               cmd,
  output bfa_pkg::dp_stat_t                stat,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [bfa_pkg::NUM_W-1:0]        allocated_number
);
  import bfa_pkg::*;

  // Latched request.
  logic             req_mode;
  logic [NUM_W-1:0] req_num;

  // Scan pipeline: scan_word is the word being read, eval_word the word whose
  // data is on the memory output.
  logic [WORD_W:0]   scan_word;
  logic [WORD_W-1:0] eval_word;
  logic              eval_live;
  logic              vld_q;
  logic              valid [MAP_DEPTH];

  logic [COUNT_W-1:0] lim;
  logic [COUNT_W-1:0] lim_m1;
  logic [WORD_W-1:0]  last_word;
  logic [BIT_W-1:0]   last_bit;

  logic [NUM_W:0]   range_lo;
  logic [NUM_W+1:0] range_hi;
  logic [NUM_W-1:0] free_off;
  logic [IDX_W-1:0] free_idx;
  logic [WORD_W-1:0] free_word;
  logic [BIT_W-1:0]  free_bit;

  logic [MAP_WORD_BITS-1:0] rdata;
  logic [MAP_WORD_BITS-1:0] word_data;
  logic [MAP_WORD_BITS-1:0] blocked;
  logic [MAP_WORD_BITS-1:0] free_bits;
  logic [MAP_WORD_BITS-1:0] low_bit;
  logic [BIT_W-1:0]         pos;
  logic [NUM_W-1:0]         alloc_num;

  logic [WORD_W-1:0]        rd_addr;
  logic [WORD_W-1:0]        wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic                     wr_en;

  // Scan limit, saturated to the map size.
  assign lim = (cfg.region_count > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
                                                         : cfg.region_count;
  assign lim_m1    = lim - COUNT_W'(1);
  assign last_word = lim_m1[IDX_W-1:BIT_W];
  assign last_bit  = lim_m1[BIT_W-1:0];

  // Free range check without wrap.
  assign range_lo  = {1'b0, cfg.region_base} + (NUM_W+1)'(cfg.first_index);
  assign range_hi  = {2'b00, cfg.region_base} + (NUM_W+2)'(lim);
  assign free_off  = req_num - cfg.region_base;
  assign free_idx  = free_off[IDX_W-1:0];
  assign free_word = free_idx[IDX_W-1:BIT_W];
  assign free_bit  = free_idx[BIT_W-1:0];

  // A word never written reads as all free.
  assign word_data = vld_q ? rdata : '0;

  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      blocked[j] = ((eval_word == '0) && cfg.first_index && (j == 0)) ||
                   ((eval_word == last_word) && (BIT_W'(j) > last_bit));
    end
  end

  assign free_bits = ~word_data & ~blocked;
  assign low_bit   = free_bits & (~free_bits + MAP_WORD_BITS'(1));

  always_comb begin
    pos = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
        if (((j >> k) & 1) == 1) begin
          pos[k] = pos[k] | low_bit[j];
        end
      end
    end
  end

  assign alloc_num = cfg.region_base + NUM_W'({eval_word, pos});

  assign rd_addr = cmd.free_read ? free_word : scan_word[WORD_W-1:0];
  assign wr_en   = cmd.alloc_write || cmd.free_write;
  assign wr_addr = cmd.alloc_write ? eval_word : free_word;
  assign wr_data = cmd.alloc_write ? (word_data | low_bit)
                                   : (word_data & ~(MAP_WORD_BITS'(1) << free_bit));

  bfa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    stat.req_mode     = req_mode;
    stat.empty_range  = (COUNT_W'(cfg.first_index) >= lim);
    stat.out_of_range = ({1'b0, req_num} < range_lo) || ({2'b00, req_num} >= range_hi);
    stat.more_words   = (scan_word <= {1'b0, last_word});
    stat.eval_live    = eval_live;
    stat.found        = |free_bits;
    stat.eval_last    = (eval_word == last_word);
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    vld_q <= valid[rd_addr];
    if (cmd.load) begin
      req_mode <= mode;
      req_num  <= entry_number;
    end
    if (cmd.issue) begin
      eval_word <= scan_word[WORD_W-1:0];
    end
    if (rst) begin
      scan_word <= '0;
      eval_live <= 1'b0;
    end else begin
      eval_live <= cmd.issue;
      if (cmd.load) begin
        scan_word <= '0;
      end else if (cmd.issue) begin
        scan_word <= scan_word + (WORD_W+1)'(1);
      end
    end
  end

  // Per-word written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status           <= cmd.resp_code;
      allocated_number <= (cmd.resp_code == ST_DONE && req_mode == MODE_ALLOC)
                          ? alloc_num : '0;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

endmodule

`default_nettype wire

@@ src/bitmap_first_fit_allocator_unit.sv @@
// Channel  | Ports                                  | Transaction
// ---------+----------------------------------------+-----------------------------------
// request  | start, busy, mode, entry_number        | start high while busy is low
// result   | done, status, allocated_number         | done high for one cycle
// config   | psel, penable, pwrite, paddr, pwdata,  | APB write: psel, penable, pwrite,
//          | prdata, pready                         | pready high (pready is tied high)
//
// A free transaction rejects a number outside the region or does a read-modify-write of one
// map word; an allocate transaction is rejected when the region is empty, else walks the map
// word by word up to the word that holds the first free entry, at worst the whole 4096-entry
// map, and the map memory is read one word per cycle. The result shows in the cycle in which
// busy drops, and the next request can be accepted in that cycle. Synchronous reset clears
// the control state and marks every map word as free at once, so a request can be accepted
// in the first cycle after reset. The receiver cannot stall: each result is shown for
// exactly one cycle.
`default_nettype none

module bitmap_first_fit_allocator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request.
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic [bfa_pkg::NUM_W-1:0]     entry_number,
  // Result.
  output logic                               done,
  output logic [1:0]                         status,
  output logic [bfa_pkg::NUM_W-1:0]          allocated_number,
  // Configuration.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfa_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bfa_pkg::DATA_W-1:0]    pwdata,
  output logic      [bfa_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);
  import bfa_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t stat;

  // The configuration registers hold the region base, the region size and the lowest index
  // that may be handed out. They must be written only while the block is idle; the block does not enforce it.
  bfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller latches a request, then either checks the free range and does a
  // read-modify-write of one map word, or walks the map word by word looking for the
  // lowest free bit, with the next read issued while the current word is examined.
  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath owns the map memory, its per-word written flags, the range arithmetic,
  // the lowest-free-bit search and the result registers.
  bfa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .mode             (mode),
    .entry_number     (entry_number),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .status           (status),
    .allocated_number (allocated_number)
  );

endmodule

`default_nettype wire

@@ src/bfa_checker.sv @@
`default_nettype none

module bfa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [1:0]                  status,
  input wire logic [bfa_pkg::NUM_W-1:0]   allocated_number
);
  import bfa_pkg::*;

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_DONE || status == ST_FULL || status == ST_RANGE))
    else $error("undefined status code on a result");

  // A failed transaction never carries an entry number.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (allocated_number == '0))
    else $error("failed result carries a nonzero number");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Results never come back to back.
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // A result is never shown while a transaction is still in progress.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

endmodule

bind bitmap_first_fit_allocator_unit bfa_checker u_bfa_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .status           (status),
  .allocated_number (allocated_number)
);

`default_nettype wire
